// ===== sv/obb_separating_axis_test_2d_assert.svh =====
// assertion macros for the 2d obb separating axis test
// used by modules that include this file; expects clk and rst in scope
`ifndef OBB_SEPARATING_AXIS_TEST_2D_ASSERT_SVH
`define OBB_SEPARATING_AXIS_TEST_2D_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define OBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obb assertion failed");
// next-cycle implication
`define OBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obb assertion failed");
`else
`define OBB_ASSERT_IMP(label, ante, cons)
`define OBB_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/obb_sat_pkg.sv =====
// shared types and constants for the 2d obb separating axis test
// no dependencies
`default_nettype none
package obb_sat_pkg;

  localparam int NUM_AXES = 4;
  localparam logic [2:0] AXIS_NONE = 3'd4;

  typedef struct packed {
    logic [63:0] left_box_min;
    logic [63:0] left_box_max;
    logic [63:0] right_box_min;
    logic [63:0] right_box_max;
    logic [63:0] left_edge_u;
    logic [63:0] left_edge_v;
    logic [63:0] right_edge_u;
    logic [63:0] right_edge_v;
    logic [63:0] center_offset;
  } obb_pair_t;

  typedef struct packed {
    logic       overlap;
    logic       box_rejected;
    logic [2:0] separating_axis;
  } obb_result_t;

  // per-stage load enables handed to the datapath units
  typedef struct packed {
    logic mul;
    logic fold;
    logic sum;
  } obb_adv_t;

endpackage
`default_nettype wire

// ===== sv/obb_separating_axis_test_2d.sv =====
// top level of the 2d oriented bounding box separating axis test
// depends on obb_sat_pkg, obb_abs_dot, obb_axis_test and the assert macro header
`default_nettype none
`include "obb_separating_axis_test_2d_assert.svh"

// Accepts one box pair per cycle while the result side does not stall, and returns
// one result word per pair, in order, from the output register. Stages: input
// register with the bounding box reject compare, 28 parallel signed products
// (COORD_BITS x COORD_BITS), dot sums and magnitudes, pair sums per axis, then the
// final add and compare per axis with the priority pick into the output register.
// Each stage holds its own valid bit; a stage loads when it is empty or the stage
// after it moves, so bubbles close up under back-pressure and nothing is dropped.
// The throughput of one pair per cycle is set by the fully parallel multiplier
// stage: four center-axis dots and ten distinct axis-axis dots.
module obb_separating_axis_test_2d import obb_sat_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pair_valid,
  output logic             pair_ready,
  input  wire obb_pair_t   pair,
  output logic             result_valid,
  input  wire logic        result_ready,
  output obb_result_t      result
);

  localparam int PW = 2 * COORD_BITS;

  function automatic logic signed [COORD_BITS-1:0] comp_x(input logic [63:0] v);
    comp_x = v[32 +: COORD_BITS];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] comp_y(input logic [63:0] v);
    comp_y = v[0 +: COORD_BITS];
  endfunction

  // stage valids and handshake chain
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4, ready5;
  obb_adv_t adv;

  assign ready5     = !result_valid || result_ready;
  assign ready4     = !v4 || ready5;
  assign ready3     = !v3 || ready4;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign pair_ready = ready1;
  assign adv.mul    = ready2;
  assign adv.fold   = ready3;
  assign adv.sum    = ready4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= pair_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
      if (ready5) result_valid <= v4;
    end
  end

  // stage 1: unpack and bounding box reject
  logic rej_next;
  logic rej1, rej2, rej3, rej4;
  logic signed [COORD_BITS-1:0] c_x, c_y;
  logic signed [COORD_BITS-1:0] ax_x [NUM_AXES];
  logic signed [COORD_BITS-1:0] ax_y [NUM_AXES];

  assign rej_next =
      (comp_x(pair.left_box_max)  < comp_x(pair.right_box_min)) ||
      (comp_x(pair.right_box_max) < comp_x(pair.left_box_min))  ||
      (comp_y(pair.left_box_max)  < comp_y(pair.right_box_min)) ||
      (comp_y(pair.right_box_max) < comp_y(pair.left_box_min));

  always_ff @(posedge clk) begin
    if (ready1) begin
      rej1    <= rej_next;
      c_x     <= comp_x(pair.center_offset);
      c_y     <= comp_y(pair.center_offset);
      ax_x[0] <= comp_x(pair.left_edge_u);
      ax_y[0] <= comp_y(pair.left_edge_u);
      ax_x[1] <= comp_x(pair.left_edge_v);
      ax_y[1] <= comp_y(pair.left_edge_v);
      ax_x[2] <= comp_x(pair.right_edge_u);
      ax_y[2] <= comp_y(pair.right_edge_u);
      ax_x[3] <= comp_x(pair.right_edge_v);
      ax_y[3] <= comp_y(pair.right_edge_v);
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) rej2 <= rej1;
    if (ready3) rej3 <= rej2;
    if (ready4) rej4 <= rej3;
  end

  // stages 2 and 3: dot magnitudes
  logic [PW-1:0] cd  [NUM_AXES];
  logic [PW-1:0] aad [NUM_AXES][NUM_AXES];
  logic [NUM_AXES-1:0] sep;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    obb_abs_dot #(.COORD_BITS(COORD_BITS)) u_cdot (
      .clk (clk),
      .adv (adv),
      .a_x (c_x),
      .a_y (c_y),
      .b_x (ax_x[i]),
      .b_y (ax_y[i]),
      .mag (cd[i])
    );
    for (genvar j = i; j < NUM_AXES; j++) begin : g_pair
      obb_abs_dot #(.COORD_BITS(COORD_BITS)) u_adot (
        .clk (clk),
        .adv (adv),
        .a_x (ax_x[i]),
        .a_y (ax_y[i]),
        .b_x (ax_x[j]),
        .b_y (ax_y[j]),
        .mag (aad[i][j])
      );
      // the axis dot table is symmetric
      if (j != i) begin : g_mirror
        assign aad[j][i] = aad[i][j];
      end
    end
    // stage 4 and the compare feeding stage 5
    obb_axis_test #(.COORD_BITS(COORD_BITS)) u_test (
      .clk (clk),
      .adv (adv),
      .cd  (cd[i]),
      .d0  (aad[i][0]),
      .d1  (aad[i][1]),
      .d2  (aad[i][2]),
      .d3  (aad[i][3]),
      .sep (sep[i])
    );
  end

  // stage 5: lowest separating axis wins; a bounding box reject overrides every axis
  obb_result_t result_next;

  always_comb begin
    result_next.overlap         = 1'b1;
    result_next.box_rejected    = 1'b0;
    result_next.separating_axis = AXIS_NONE;
    for (int k = NUM_AXES - 1; k >= 0; k--) begin
      if (sep[k]) begin
        result_next.overlap         = 1'b0;
        result_next.separating_axis = 3'(k);
      end
    end
    if (rej4) begin
      result_next.overlap         = 1'b0;
      result_next.box_rejected    = 1'b1;
      result_next.separating_axis = AXIS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) result <= result_next;
  end

  `OBB_ASSERT_IMP(a_full_when_blocked, !pair_ready,
      v1 && v2 && v3 && v4 && result_valid && !result_ready)
  `OBB_ASSERT_NXT(a_stage1_holds, v1 && !ready2, v1 && $stable(rej1))
  `OBB_ASSERT_IMP(a_overlap_no_axis, result_valid && result.overlap,
      !result.box_rejected && result.separating_axis == AXIS_NONE)
  `OBB_ASSERT_IMP(a_separated_has_axis,
      result_valid && !result.overlap && !result.box_rejected,
      result.separating_axis != AXIS_NONE)

endmodule
`default_nettype wire

// ===== sv/obb_abs_dot.sv =====
// absolute value of a 2d dot product, two register stages
// depends on obb_sat_pkg (obb_adv_t)
`default_nettype none
module obb_abs_dot import obb_sat_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire obb_adv_t                     adv,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  output logic [2*COORD_BITS-1:0]           mag
);

  localparam int PW = 2 * COORD_BITS;

  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic        [PW:0]   dot_sum;
  logic        [PW:0]   dot_neg;

  always_ff @(posedge clk) begin
    if (adv.mul) begin
      px <= a_x * b_x;
      py <= a_y * b_y;
    end
  end

  assign dot_sum = {px[PW-1], px} + {py[PW-1], py};
  assign dot_neg = ~dot_sum + {{PW{1'b0}}, 1'b1};

  // magnitude never exceeds 2^(PW-1), so it fits in PW bits
  always_ff @(posedge clk) begin
    if (adv.fold) begin
      mag <= dot_sum[PW] ? dot_neg[PW-1:0] : dot_sum[PW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/obb_axis_test.sv =====
// separation test on one candidate axis: 2*|c.a| > sum of |a.a_j|
// depends on obb_sat_pkg (obb_adv_t)
`default_nettype none
module obb_axis_test import obb_sat_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                        clk,
  input  wire obb_adv_t                    adv,
  input  wire logic [2*COORD_BITS-1:0]     cd,
  input  wire logic [2*COORD_BITS-1:0]     d0,
  input  wire logic [2*COORD_BITS-1:0]     d1,
  input  wire logic [2*COORD_BITS-1:0]     d2,
  input  wire logic [2*COORD_BITS-1:0]     d3,
  output logic                             sep
);

  localparam int PW = 2 * COORD_BITS;

  logic [PW:0]   sum01;
  logic [PW:0]   sum23;
  logic [PW:0]   lhs;
  logic [PW+1:0] total;

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      sum01 <= {1'b0, d0} + {1'b0, d1};
      sum23 <= {1'b0, d2} + {1'b0, d3};
      lhs   <= {cd, 1'b0};
    end
  end

  // equality does not separate
  assign total = {1'b0, sum01} + {1'b0, sum23};
  assign sep   = {1'b0, lhs} > total;

endmodule
`default_nettype wire
